[hdl/gas_pkg.sv]
`default_nettype none

package gas_pkg;

	// Default geometry and node pool size.
	localparam int MAP_WIDTH_DEF  = 32;
	localparam int MAP_HEIGHT_DEF = 32;
	localparam int NODE_POOL_DEF  = 320;

	// Cost of one step between neighboring cells.
	localparam int STEP_COST = 10;

	// Fixed field widths of the item ports.
	localparam int OP_W       = 2;
	localparam int CELL_IDX_W = 10;
	localparam int COORD_W    = 5;
	localparam int STEP_IDX_W = 9;
	localparam int LEN_W      = 9;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WRITE_CELL = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH     = 2'd1;
	localparam logic [OP_W-1:0] OP_READ_STEP  = 2'd2;

	// Write strobes and data toward the cell maps.
	typedef struct packed {
		logic map_we;
		logic map_wdata;
		logic cls_we;
		logic cls_wdata;
	} gas_cellwr_t;

endpackage

`default_nettype wire

[hdl/gas_cost_unit.sv]
`default_nettype none

module gas_cost_unit
	import gas_pkg::*;
#(
	parameter int XW = 5,
	parameter int YW = 5,
	parameter int FW = 16
) (
	input  wire logic [XW-1:0] x,
	input  wire logic [YW-1:0] y,
	input  wire logic [XW-1:0] gx,
	input  wire logic [YW-1:0] gy,
	input  wire logic [FW-1:0] g_base,
	input  wire logic          add_step,
	output logic      [FW-1:0] g_out,
	output logic      [FW-1:0] f_out
);

	localparam int SW = ((XW > YW) ? XW : YW) + 1;

	logic [XW-1:0] dx;
	logic [YW-1:0] dy;
	logic [SW-1:0] dsum;
	logic [FW-1:0] heur;

	// Heuristic is ten times the Manhattan distance, built from two shifts.
	always_comb begin
		dx    = (x > gx) ? (x - gx) : (gx - x);
		dy    = (y > gy) ? (y - gy) : (gy - y);
		dsum  = SW'(dx) + SW'(dy);
		heur  = (FW'(dsum) << 3) + (FW'(dsum) << 1);
		g_out = add_step ? (g_base + FW'(STEP_COST)) : g_base;
		f_out = g_out + heur;
	end

endmodule

`default_nettype wire

[hdl/gas_cell_maps.sv]
`default_nettype none

module gas_cell_maps
	import gas_pkg::*;
#(
	parameter int CELLS = 1024,
	parameter int CIW   = 10
) (
	input  wire logic           clk,
	input  wire logic [CIW-1:0] wr_addr,
	input  wire gas_cellwr_t    wr,
	input  wire logic [CIW-1:0] rd_addr,
	output logic                map_rd_q,
	output logic                cls_rd_q
);

	// Walkable map and per-search closed map, one bit per cell each.
	logic map_mem [CELLS];
	logic cls_mem [CELLS];

	always_ff @(posedge clk) begin
		if (wr.map_we) begin
			map_mem[wr_addr] <= wr.map_wdata;
		end
		if (wr.cls_we) begin
			cls_mem[wr_addr] <= wr.cls_wdata;
		end
		map_rd_q <= map_mem[rd_addr];
		cls_rd_q <= cls_mem[rd_addr];
	end

endmodule

`default_nettype wire

[hdl/grid_astar_path_search.sv]
`default_nettype none

// Grid A* path search with four neighbors over a MAP_WIDTH x MAP_HEIGHT map. Every input
// transfer yields exactly one output transfer. Op 0 writes one map cell, op 1 runs a search
// from a start cell to a goal cell, op 2 reads one step of the last path, and op 3 only
// reports status. After reset the block clears the map and holds in_stall high meanwhile.
// A search first clears the closed map, then runs expansions: each expansion scans all
// nodes created so far through the single node memory read port, one node per cycle, and
// spends the NB_ADDR and NB_CHECK states per neighbor on the cell map lookup. Rebuilding a
// found path steps through PATH_WR and PATH_LD for each path cell. The result is held in
// an output register, so the block takes and works on the next item while the previous
// result waits; it holds in ST_DONE until that register is free.

module grid_astar_path_search
	import gas_pkg::*;
#(
	parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
	parameter int NODE_POOL  = NODE_POOL_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [OP_W-1:0]       op,
	input  wire logic [CELL_IDX_W-1:0] cell_index,
	input  wire logic                  cell_open,
	input  wire logic [COORD_W-1:0]    start_x,
	input  wire logic [COORD_W-1:0]    start_y,
	input  wire logic [COORD_W-1:0]    goal_x,
	input  wire logic [COORD_W-1:0]    goal_y,
	input  wire logic [STEP_IDX_W-1:0] step_index,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       found,
	output logic [LEN_W-1:0]           path_length,
	output logic [COORD_W-1:0]         step_x,
	output logic [COORD_W-1:0]         step_y
);

	// Coordinates must hold both the start and goal fields and any cell of the map.
	localparam int XW    = ($clog2(MAP_WIDTH) > COORD_W) ? $clog2(MAP_WIDTH) : COORD_W;
	localparam int YW    = ($clog2(MAP_HEIGHT) > COORD_W) ? $clog2(MAP_HEIGHT) : COORD_W;
	localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
	localparam int CIW   = $clog2(CELLS);
	localparam int NIW   = $clog2(NODE_POOL);
	localparam int LW    = NIW;
	localparam int CMPW  = (LW > STEP_IDX_W) ? LW : STEP_IDX_W;
	localparam int FW    = $clog2(STEP_COST * (NODE_POOL + MAP_WIDTH + MAP_HEIGHT
		+ 2 * (1 << COORD_W)) + 1);
	localparam int PW    = 2 * COORD_W;

	typedef struct packed {
		logic [XW-1:0]  x;
		logic [YW-1:0]  y;
		logic [FW-1:0]  g;
		logic [FW-1:0]  f;
		logic [NIW-1:0] parent;
		logic           closed;
	} node_t;

	typedef enum logic [10:0] {
		ST_CLEAR    = 11'b00000000001,
		ST_IDLE     = 11'b00000000010,
		ST_INIT     = 11'b00000000100,
		ST_SCAN     = 11'b00000001000,
		ST_POP      = 11'b00000010000,
		ST_NB_ADDR  = 11'b00000100000,
		ST_NB_CHECK = 11'b00001000000,
		ST_PATH_WR  = 11'b00010000000,
		ST_PATH_LD  = 11'b00100000000,
		ST_STEP_LD  = 11'b01000000000,
		ST_DONE     = 11'b10000000000
	} state_t;

	function automatic logic [CIW-1:0] cell_of(input logic [XW-1:0] cx, input logic [YW-1:0] cy);
		return CIW'(32'(cy) * 32'(MAP_WIDTH) + 32'(cx));
	endfunction

	// Sequencer and search state.
	state_t         state_q;
	logic           clr_map_q;
	logic [CIW-1:0] sweep_q;
	logic [XW-1:0]  sx_q;
	logic [YW-1:0]  sy_q;
	logic [XW-1:0]  gx_q;
	logic [YW-1:0]  gy_q;
	logic [LW-1:0]  last_len_q;
	logic [NIW-1:0] used_q;
	logic [NIW-1:0] scan_q;
	logic           rd_v_s1;
	logic [NIW-1:0] rd_idx_s1;
	node_t          best_q;
	logic [NIW-1:0] best_idx_q;
	logic           have_best_q;
	logic [1:0]     k_q;
	node_t          path_node_q;
	logic [NIW-1:0] pidx_q;
	logic [LW-1:0]  pcnt_q;
	logic [COORD_W-1:0] stx_q;
	logic [COORD_W-1:0] sty_q;

	// Output register.
	logic               out_valid_q;
	logic               found_q;
	logic [LEN_W-1:0]   len_out_q;
	logic [COORD_W-1:0] stx_out_q;
	logic [COORD_W-1:0] sty_out_q;

	// Node and path memories.
	node_t          node_mem [NODE_POOL];
	node_t          node_rd_q;
	logic           node_we;
	logic [NIW-1:0] node_waddr;
	node_t          node_wdata;
	logic [NIW-1:0] node_raddr;

	logic [PW-1:0]  path_mem [NODE_POOL];
	logic [PW-1:0]  path_rd_q;
	logic [NIW-1:0] path_raddr;

	// Cell maps.
	gas_cellwr_t    cw;
	logic [CIW-1:0] cw_addr;
	logic [CIW-1:0] cr_addr;
	logic           map_rd_q;
	logic           cls_rd_q;

	// Shared cost unit.
	logic [XW-1:0] cu_x;
	logic [YW-1:0] cu_y;
	logic [FW-1:0] cu_g_base;
	logic          cu_add;
	logic [FW-1:0] cu_g;
	logic [FW-1:0] cu_f;

	// Neighbor and misc decode.
	logic          accept;
	logic [XW:0]   nx;
	logic [YW:0]   ny;
	logic          nb_in;
	logic          nb_ok;
	logic          best_in;
	logic          at_goal;
	logic          take;
	logic [CMPW-1:0] st_ext;
	logic [CMPW-1:0] len_ext;
	logic          st_ok;
	logic          cell_ok;
	logic          out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Neighbors are examined y+1, x-1, x+1, y-1 so that they are created in that order;
	// the scan rule below turns this into the queueing order of the search.
	// A step left from column zero wraps to all ones and falls off the map.
	always_comb begin
		nx = {1'b0, best_q.x};
		ny = {1'b0, best_q.y};
		case (k_q)
			2'd0: ny = {1'b0, best_q.y} + 1'b1;
			2'd1: nx = {1'b0, best_q.x} - 1'b1;
			2'd2: nx = {1'b0, best_q.x} + 1'b1;
			default: ny = {1'b0, best_q.y} - 1'b1;
		endcase
		nb_in   = (nx < (XW+1)'(MAP_WIDTH)) && (ny < (YW+1)'(MAP_HEIGHT));
		nb_ok   = nb_in && map_rd_q && !cls_rd_q;
		best_in = ({1'b0, best_q.x} < (XW+1)'(MAP_WIDTH))
			&& ({1'b0, best_q.y} < (YW+1)'(MAP_HEIGHT));
		at_goal = (best_q.x == gx_q) && (best_q.y == gy_q);
	end

	// Minimum search over the node store. Open nodes appear in creation order; an
	// expansion appends its children in neighbor order, so on equal F a later node wins only
	// when it comes from a different expansion than the current best.
	always_comb begin
		take = rd_v_s1 && !node_rd_q.closed && (!have_best_q || (node_rd_q.f < best_q.f)
			|| ((node_rd_q.f == best_q.f) && (node_rd_q.parent != best_q.parent)));
	end

	// Path read request for op 2. The path is stored from the goal backwards.
	always_comb begin
		st_ext     = CMPW'(step_index);
		len_ext    = CMPW'(last_len_q);
		st_ok      = st_ext < len_ext;
		path_raddr = NIW'(len_ext - st_ext - 1'b1);
		cell_ok    = 32'(cell_index) < 32'(CELLS);
	end

	// Shared cost unit: start node in INIT, new neighbor otherwise.
	always_comb begin
		if (state_q == ST_INIT) begin
			cu_x      = sx_q;
			cu_y      = sy_q;
			cu_g_base = '0;
			cu_add    = 1'b0;
		end else begin
			cu_x      = nx[XW-1:0];
			cu_y      = ny[YW-1:0];
			cu_g_base = best_q.g;
			cu_add    = 1'b1;
		end
	end

	gas_cost_unit #(
		.XW(XW),
		.YW(YW),
		.FW(FW)
	) u_cost (
		.x(cu_x),
		.y(cu_y),
		.gx(gx_q),
		.gy(gy_q),
		.g_base(cu_g_base),
		.add_step(cu_add),
		.g_out(cu_g),
		.f_out(cu_f)
	);

	// Cell map access.
	always_comb begin
		cw      = '0;
		cw_addr = sweep_q;
		cr_addr = nb_in ? cell_of(nx[XW-1:0], ny[YW-1:0]) : '0;
		case (state_q)
			ST_CLEAR: begin
				cw.map_we = clr_map_q;
				cw.cls_we = 1'b1;
			end
			ST_IDLE: begin
				if (accept && (op == OP_WRITE_CELL) && cell_ok) begin
					cw.map_we    = 1'b1;
					cw.map_wdata = cell_open;
					cw_addr      = CIW'(cell_index);
				end
			end
			ST_POP: begin
				if (have_best_q && best_in) begin
					cw.cls_we    = 1'b1;
					cw.cls_wdata = 1'b1;
					cw_addr      = cell_of(best_q.x, best_q.y);
				end
			end
			default: begin
			end
		endcase
	end

	gas_cell_maps #(
		.CELLS(CELLS),
		.CIW(CIW)
	) u_maps (
		.clk(clk),
		.wr_addr(cw_addr),
		.wr(cw),
		.rd_addr(cr_addr),
		.map_rd_q(map_rd_q),
		.cls_rd_q(cls_rd_q)
	);

	// Node store access.
	always_comb begin
		node_we    = 1'b0;
		node_waddr = used_q;
		node_wdata = best_q;
		node_raddr = scan_q;
		case (state_q)
			ST_INIT: begin
				node_we    = 1'b1;
				node_waddr = '0;
				node_wdata = '{x: sx_q, y: sy_q, g: '0, f: cu_f, parent: '0, closed: 1'b0};
			end
			ST_POP: begin
				node_we           = have_best_q;
				node_waddr        = best_idx_q;
				node_wdata.closed = 1'b1;
			end
			ST_NB_CHECK: begin
				node_we    = nb_ok && (used_q < NIW'(NODE_POOL - 1));
				node_wdata = '{x: nx[XW-1:0], y: ny[YW-1:0], g: cu_g, f: cu_f,
					parent: best_idx_q, closed: 1'b0};
			end
			ST_PATH_WR: begin
				node_raddr = path_node_q.parent;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		node_rd_q <= node_mem[node_raddr];
		if (state_q == ST_PATH_WR) begin
			path_mem[pcnt_q] <= {path_node_q.x[COORD_W-1:0], path_node_q.y[COORD_W-1:0]};
		end
		path_rd_q <= path_mem[path_raddr];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					stx_q <= '0;
					sty_q <= '0;
					if (op == OP_SEARCH) begin
						sx_q <= XW'(start_x);
						sy_q <= YW'(start_y);
						gx_q <= XW'(goal_x);
						gy_q <= YW'(goal_y);
					end
				end
			end
			ST_SCAN: begin
				rd_idx_s1 <= scan_q;
				if (take) begin
					best_q     <= node_rd_q;
					best_idx_q <= rd_idx_s1;
				end
			end
			ST_POP: begin
				path_node_q <= best_q;
				pidx_q      <= best_idx_q;
			end
			ST_PATH_WR: begin
				pidx_q <= path_node_q.parent;
			end
			ST_PATH_LD: begin
				path_node_q <= node_rd_q;
			end
			ST_STEP_LD: begin
				stx_q <= path_rd_q[PW-1:COORD_W];
				sty_q <= path_rd_q[COORD_W-1:0];
			end
			ST_DONE: begin
				if (out_free) begin
					found_q   <= (last_len_q != '0);
					len_out_q <= LEN_W'(last_len_q);
					stx_out_q <= stx_q;
					sty_out_q <= sty_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_map_q   <= 1'b1;
			sweep_q     <= '0;
			last_len_q  <= '0;
			used_q      <= '0;
			scan_q      <= '0;
			rd_v_s1     <= 1'b0;
			have_best_q <= 1'b0;
			k_q         <= '0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == CIW'(CELLS - 1)) begin
						sweep_q <= '0;
						if (clr_map_q) begin
							clr_map_q <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							state_q <= ST_INIT;
						end
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_WRITE_CELL: state_q <= ST_DONE;
							OP_SEARCH: begin
								last_len_q <= '0;
								state_q    <= ST_CLEAR;
							end
							OP_READ_STEP: state_q <= st_ok ? ST_STEP_LD : ST_DONE;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_INIT: begin
					used_q      <= NIW'(1);
					scan_q      <= '0;
					have_best_q <= 1'b0;
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_q < used_q) begin
						rd_v_s1 <= 1'b1;
						scan_q  <= scan_q + 1'b1;
					end
					if (take) begin
						have_best_q <= 1'b1;
					end
					if ((scan_q == used_q) && !rd_v_s1) begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					if (!have_best_q) begin
						// The open list ran dry: no route.
						state_q <= ST_DONE;
					end else if (at_goal) begin
						pcnt_q  <= '0;
						state_q <= ST_PATH_WR;
					end else begin
						k_q     <= '0;
						state_q <= ST_NB_ADDR;
					end
				end
				ST_NB_ADDR: begin
					state_q <= ST_NB_CHECK;
				end
				ST_NB_CHECK: begin
					if (nb_ok && (used_q >= NIW'(NODE_POOL - 1))) begin
						// Node pool exhausted: the search fails.
						state_q <= ST_DONE;
					end else begin
						if (nb_ok) begin
							used_q <= used_q + 1'b1;
						end
						if (k_q == 2'd3) begin
							scan_q      <= '0;
							have_best_q <= 1'b0;
							state_q     <= ST_SCAN;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_NB_ADDR;
						end
					end
				end
				ST_PATH_WR: begin
					pcnt_q <= pcnt_q + 1'b1;
					if (pidx_q == '0) begin
						last_len_q <= pcnt_q + 1'b1;
						state_q    <= ST_DONE;
					end else begin
						state_q <= ST_PATH_LD;
					end
				end
				ST_PATH_LD: begin
					state_q <= ST_PATH_WR;
				end
				ST_STEP_LD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign path_length = len_out_q;
	assign step_x      = stx_out_q;
	assign step_y      = sty_out_q;

endmodule

`default_nettype wire

[hdl/gas_checker.sv]
`default_nettype none

module gas_checker
	import gas_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic               found,
	input wire logic [LEN_W-1:0]   path_length,
	input wire logic [COORD_W-1:0] step_x,
	input wire logic [COORD_W-1:0] step_y
);

	// Status fields agree: a path was found exactly when it has cells.
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (found == (path_length != '0)))
		else $error("found and path_length disagree");

	// Without a path there is no step to report.
	a_no_path_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> ((step_x == '0) && (step_y == '0)))
		else $error("step reported without a path");

	// One item is worked on at a time.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("new transfer taken while busy");

	// A held result keeps its valid, found flag and path length.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(path_length) && $stable(found)))
		else $error("stalled result changed");

endmodule

bind grid_astar_path_search gas_checker u_gas_checker (.*);

`default_nettype wire
